// ===== rtl/joystick_event_to_key_edges_unit_macros.svh =====
// Assertion macros for the joystick event to key edge unit.
// Included by the top level; no other dependencies.
`ifndef JOYSTICK_EVENT_TO_KEY_EDGES_UNIT_MACROS_SVH
`define JOYSTICK_EVENT_TO_KEY_EDGES_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define JEKE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jeke same-cycle check failed");
// Next-cycle implication, checked outside reset
`define JEKE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jeke next-cycle check failed");
`else
`define JEKE_ASSERT_IMP(label, clk, rst, ante, cons)
`define JEKE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/jeke_pkg.sv =====
// Shared constants and types of the joystick event to key edge unit.
// No dependencies.
`default_nettype none

package jeke_pkg;

  localparam int NUM_BUTTONS_DEF = 32;
  localparam int NUM_AXES_DEF    = 8;
  localparam int MAX_RESULTS     = 48;
  localparam int CNT_W           = 6;
  localparam int KEY_IDX_W       = 5;

  localparam int THR_W           = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd4915;

  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 15;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ENABLE  = 1'b1;

  localparam logic [1:0] CMD_BUTTON  = 2'd0;
  localparam logic [1:0] CMD_AXIS    = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;
  localparam logic [1:0] CMD_RELEASE = 2'd3;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/jeke_front.sv =====
// Front part: config registers, request decode, joystick state, job build.
// Depends on jeke_pkg.
`default_nettype none

module jeke_front #(
  parameter int NUM_BUTTONS = jeke_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_AXES    = jeke_pkg::NUM_AXES_DEF,
  parameter int W           = NUM_BUTTONS + 2 * NUM_AXES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wen,
  input  wire logic [jeke_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [jeke_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [23:0]                     s_tdata,
  input  wire logic [1:0]                      s_tuser,
  input  wire jeke_pkg::q_stat_t               q_stat,
  output logic                                 push,
  output logic [W-1:0]                         push_mask,
  output logic [W-1:0]                         push_val
);

  localparam int DW = 2 * NUM_AXES;

  logic [jeke_pkg::THR_W-1:0] axis_threshold;
  logic                       device_enable;
  logic [NUM_BUTTONS-1:0]     held_buttons;
  logic [DW-1:0]              held_dirs;
  logic signed [15:0]         axis_samples [NUM_AXES];

  logic                    accept;
  logic                    take;
  logic [1:0]              cmd;
  logic [7:0]              num;
  logic signed [15:0]      value;
  logic                    level;
  logic [NUM_BUTTONS-1:0]  btn_sel;
  logic [NUM_BUTTONS-1:0]  btn_change;
  logic [NUM_BUTTONS-1:0]  held_buttons_next;
  logic [NUM_AXES-1:0]     axis_sel;
  logic [DW-1:0]           dirs;
  logic signed [16:0]      thr_pos;
  logic signed [16:0]      thr_neg;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      axis_threshold <= jeke_pkg::THR_RESET;
      device_enable  <= 1'b1;
    end else if (cfg_wen) begin
      case (cfg_index)
        jeke_pkg::REG_AXIS_THRESHOLD: axis_threshold <= cfg_data[jeke_pkg::THR_W-1:0];
        jeke_pkg::REG_DEVICE_ENABLE:  device_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Take a request whenever the queue has room
  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;
  assign take     = accept && device_enable;

  assign cmd   = s_tuser;
  assign num   = s_tdata[7:0];
  assign value = $signed(s_tdata[23:8]);
  assign level = (value != 16'sd0);

  // Decode button and axis selects; out-of-range numbers select nothing
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      btn_sel[i] = (num == 8'(i));
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      axis_sel[i] = (num == 8'(i));
    end
  end

  assign btn_change        = btn_sel & (level ? ~held_buttons : held_buttons);
  assign held_buttons_next = level ? (held_buttons | btn_sel) : (held_buttons & ~btn_sel);

  // Classify every axis against the threshold window
  assign thr_pos = $signed({2'b00, axis_threshold});
  assign thr_neg = -thr_pos;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      dirs[2*i]   = (17'(axis_samples[i]) < thr_neg);
      dirs[2*i+1] = (17'(axis_samples[i]) > thr_pos);
    end
  end

  // Build the job: bits to report and their press levels
  always_comb begin
    push_mask = '0;
    push_val  = '0;
    case (cmd)
      jeke_pkg::CMD_BUTTON: begin
        push_mask = {{DW{1'b0}}, btn_change};
        push_val  = {{DW{1'b0}}, {NUM_BUTTONS{level}}};
      end
      jeke_pkg::CMD_TICK: begin
        push_mask = {dirs ^ held_dirs, {NUM_BUTTONS{1'b0}}};
        push_val  = {dirs, {NUM_BUTTONS{1'b0}}};
      end
      jeke_pkg::CMD_RELEASE: begin
        push_mask = {held_dirs, held_buttons};
      end
      default: ;
    endcase
  end

  assign push = take && (|push_mask);

  // Update joystick state on each taken request
  always_ff @(posedge clk) begin
    if (rst) begin
      held_buttons <= '0;
      held_dirs    <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_samples[i] <= '0;
      end
    end else if (take) begin
      case (cmd)
        jeke_pkg::CMD_BUTTON: held_buttons <= held_buttons_next;
        jeke_pkg::CMD_AXIS: begin
          for (int i = 0; i < NUM_AXES; i++) begin
            if (axis_sel[i]) axis_samples[i] <= value;
          end
        end
        jeke_pkg::CMD_TICK: held_dirs <= dirs;
        jeke_pkg::CMD_RELEASE: begin
          held_buttons <= '0;
          held_dirs    <= '0;
          for (int i = 0; i < NUM_AXES; i++) begin
            axis_samples[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jeke_queue.sv =====
// Short job queue between the front and back parts.
// Depends on jeke_pkg.
`default_nettype none

module jeke_queue #(
  parameter int DATA_W = 2 * (jeke_pkg::NUM_BUTTONS_DEF + 2 * jeke_pkg::NUM_AXES_DEF)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      pop_data,
  output jeke_pkg::q_stat_t      stat
);

  logic [DATA_W-1:0]       slots [jeke_pkg::Q_DEPTH];
  logic [jeke_pkg::Q_AW-1:0] wr_ptr;
  logic [jeke_pkg::Q_AW-1:0] rd_ptr;
  logic [jeke_pkg::Q_AW:0]   fill;

  assign stat.full  = (fill == (jeke_pkg::Q_AW+1)'(jeke_pkg::Q_DEPTH));
  assign stat.empty = (fill == '0);
  assign pop_data   = slots[rd_ptr];

  // Store job payload
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jeke_back.sv =====
// Back part: walks one job bit per cycle while the output slot is free, and drives the key output register.
// Depends on jeke_pkg.
`default_nettype none

module jeke_back #(
  parameter int NUM_BUTTONS = jeke_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_AXES    = jeke_pkg::NUM_AXES_DEF,
  parameter int W           = NUM_BUTTONS + 2 * NUM_AXES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire jeke_pkg::q_stat_t q_stat,
  output logic                   pop,
  input  wire logic [W-1:0]      job_mask,
  input  wire logic [W-1:0]      job_val,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata,
  output logic                   m_tuser,
  output logic                   m_tlast
);

  localparam int PW = $clog2(W);

  logic                              busy;
  logic [W-1:0]                      mask;
  logic [W-1:0]                      val;
  logic [PW-1:0]                     pos;
  logic [jeke_pkg::CNT_W-1:0]        count;

  logic                              out_valid;
  logic                              out_group;
  logic [jeke_pkg::KEY_IDX_W-1:0]    out_index;
  logic                              out_pressed;
  logic                              out_last;

  logic                              out_free;
  logic                              hit;
  logic [W-1:0]                      rest;
  logic [jeke_pkg::CNT_W-1:0]        count_next;
  logic                              cap;
  logic                              is_button;
  logic [PW-1:0]                     pos_dir;
  logic [jeke_pkg::KEY_IDX_W-1:0]    key_idx;

  assign out_free   = !out_valid || m_tready;
  assign pop        = !busy && !q_stat.empty;
  assign hit        = mask[0];
  assign rest       = mask >> 1;
  assign count_next = count + 1'b1;
  assign cap        = (count_next == jeke_pkg::CNT_W'(jeke_pkg::MAX_RESULTS));
  assign is_button  = (pos < PW'(NUM_BUTTONS));
  assign pos_dir    = pos - PW'(NUM_BUTTONS);
  assign key_idx    = is_button ? jeke_pkg::KEY_IDX_W'(pos)
                                : jeke_pkg::KEY_IDX_W'(pos_dir);

  // Load a job, then step one bit position per free output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      mask  <= '0;
      val   <= '0;
      pos   <= '0;
      count <= '0;
    end else if (pop) begin
      busy  <= 1'b1;
      mask  <= job_mask;
      val   <= job_val;
      pos   <= '0;
      count <= '0;
    end else if (busy && out_free) begin
      mask <= rest;
      val  <= val >> 1;
      pos  <= pos + 1'b1;
      if (hit) count <= count_next;
      // Drop the job at its final bit or at the result cap
      if ((rest == '0) || (hit && cap)) busy <= 1'b0;
    end
  end

  // Output register; refill whenever the slot frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= busy && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && out_free && hit) begin
      out_group   <= !is_button;
      out_index   <= key_idx;
      out_pressed <= val[0];
      out_last    <= (rest == '0) || cap;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_pressed, out_index};
  assign m_tuser  = out_group;
  assign m_tlast  = out_last;

endmodule

`default_nettype wire

// ===== rtl/joystick_event_to_key_edges_unit.sv =====
// Top level of the joystick event to key edge unit: front, queue and back.
// Depends on jeke_pkg, jeke_front, jeke_queue, jeke_back and the macro header.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------------------
//   config   | in        | cfg_wen            | cfg_index, cfg_data
//   s_*      | in        | s_tvalid/s_tready  | s_tdata, s_tuser (command)
//   m_*      | out       | m_tvalid/m_tready  | m_tdata, m_tuser (group), m_tlast
//
// The front takes a request whenever the two-entry job queue has room.
// The back loads a job, then steps one bit position per free output slot up to the
// last key it reports or the per-request result cap.
// Reset (rst, synchronous) clears all joystick state and restores register defaults.
// A stalled m_tready holds the back; the front keeps taking requests until the queue fills.
`default_nettype none
`include "joystick_event_to_key_edges_unit_macros.svh"

module joystick_event_to_key_edges_unit #(
  parameter int NUM_BUTTONS = jeke_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_AXES    = jeke_pkg::NUM_AXES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wen,
  input  wire logic [jeke_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [jeke_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [23:0]                     s_tdata,   // control_number[7:0], event_value[23:8]
  input  wire logic [1:0]                      s_tuser,   // cmd[1:0]
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [7:0]                           m_tdata,   // key_index[4:0], pressed[5], zero[7:6]
  output logic                                 m_tuser,   // key_group[0]
  output logic                                 m_tlast
);

  localparam int W = NUM_BUTTONS + 2 * NUM_AXES;

  jeke_pkg::q_stat_t q_stat;
  logic              q_push;
  logic              q_pop;
  logic [W-1:0]      push_mask;
  logic [W-1:0]      push_val;
  logic [2*W-1:0]    pop_data;

  jeke_front #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .NUM_AXES    (NUM_AXES),
    .W           (W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_mask (push_mask),
    .push_val  (push_val)
  );

  jeke_queue #(
    .DATA_W (2 * W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({push_val, push_mask}),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  jeke_back #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .NUM_AXES    (NUM_AXES),
    .W           (W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .pop      (q_pop),
    .job_mask (pop_data[W-1:0]),
    .job_val  (pop_data[2*W-1:W]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Checks on queue traffic and key numbering
  `JEKE_ASSERT_IMP(a_push_has_room, clk, rst, q_push, !q_stat.full)
  `JEKE_ASSERT_IMP(a_pop_has_job, clk, rst, q_pop, !q_stat.empty)
  `JEKE_ASSERT_NXT(a_push_fills, clk, rst, q_push && !q_pop, !q_stat.empty)
  `JEKE_ASSERT_IMP(a_button_in_range, clk, rst, m_tvalid && !m_tuser, 32'(m_tdata[4:0]) < 32'(NUM_BUTTONS))

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for joystick_event_to_key_edges_unit: button, axis, tick and
// release-all requests in, key press/release events out, checked against a local model.
// Depends on jeke_pkg and the RTL of the unit.
module tb_top;
  import jeke_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 160;

  typedef struct packed {
    logic                 group;
    logic [KEY_IDX_W-1:0] index;
    logic                 pressed;
    logic                 last;
  } key_event_t;

  // Joystick state model and the queue of key events it still owes
  class key_edge_predictor;
    key_event_t                 expected_keys[$];
    int unsigned                mismatches;
    logic [NUM_BUTTONS_DEF-1:0] held_buttons;
    logic signed [15:0]         axis_samples [NUM_AXES_DEF];
    logic [2*NUM_AXES_DEF-1:0]  held_dirs;
    int                         threshold;
    bit                         enabled;
    int                         item_keys;

    function new();
      threshold  = int'(THR_RESET);
      enabled    = 1'b1;
      mismatches = 0;
      clear_joystick();
    endfunction

    function void clear_joystick();
      held_buttons = '0;
      held_dirs    = '0;
      foreach (axis_samples[i]) axis_samples[i] = '0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_AXIS_THRESHOLD) begin
        threshold = int'(data);
      end else begin
        enabled = data[0];
      end
    endfunction

    // Queue one key event; drop anything past the per-request cap
    function void push_key(logic group, int idx, logic pressed);
      key_event_t k;
      if (item_keys >= MAX_RESULTS) return;
      k.group   = group;
      k.index   = idx[KEY_IDX_W-1:0];
      k.pressed = pressed;
      k.last    = 1'b0;
      expected_keys.push_back(k);
      item_keys++;
    endfunction

    function void accept_request(logic [1:0] cmd, logic [7:0] num, logic [15:0] value);
      logic [2*NUM_AXES_DEF-1:0] dirs;
      int                        sample;
      item_keys = 0;
      if (!enabled) return;
      case (cmd)
        CMD_BUTTON: begin
          if (num < NUM_BUTTONS_DEF) begin
            if (value != 0 && !held_buttons[num]) push_key(1'b0, int'(num), 1'b1);
            else if (value == 0 && held_buttons[num]) push_key(1'b0, int'(num), 1'b0);
            held_buttons[num] = (value != 0);
          end
        end
        CMD_AXIS: begin
          if (num < NUM_AXES_DEF) axis_samples[num] = $signed(value);
        end
        CMD_TICK: begin
          // Strict compare against +/- threshold, negative direction in the even bit
          dirs = '0;
          for (int i = 0; i < NUM_AXES_DEF; i++) begin
            sample = int'(axis_samples[i]);
            if (sample < -threshold) dirs[2*i] = 1'b1;
            else if (sample > threshold) dirs[2*i+1] = 1'b1;
          end
          for (int i = 0; i < 2*NUM_AXES_DEF; i++) begin
            if (dirs[i] != held_dirs[i]) push_key(1'b1, i, dirs[i]);
          end
          held_dirs = dirs;
        end
        default: begin
          // Release buttons first, then direction keys, then forget everything
          for (int i = 0; i < NUM_BUTTONS_DEF; i++) begin
            if (held_buttons[i]) push_key(1'b0, i, 1'b0);
          end
          for (int i = 0; i < 2*NUM_AXES_DEF; i++) begin
            if (held_dirs[i]) push_key(1'b1, i, 1'b0);
          end
          clear_joystick();
        end
      endcase
      if (item_keys > 0) expected_keys[expected_keys.size()-1].last = 1'b1;
    endfunction

    function void check_key(key_event_t got);
      key_event_t want;
      if (expected_keys.size() == 0) begin
        $display("%0t: unexpected key event: group %0d index %0d pressed %0d last %0d",
                 $time, got.group, got.index, got.pressed, got.last);
        mismatches++;
        return;
      end
      want = expected_keys.pop_front();
      if (got !== want) begin
        $display("%0t: key event mismatch: expected group %0d index %0d pressed %0d last %0d",
                 $time, want.group, want.index, want.pressed, want.last);
        $display("%0t:                     actual   group %0d index %0d pressed %0d last %0d",
                 $time, got.group, got.index, got.pressed, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [23:0]           s_tdata   = '0;  // control_number[7:0], event_value[23:8]
  logic [1:0]            s_tuser   = '0;  // cmd[1:0]
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [7:0]            m_tdata;         // key_index[4:0], pressed[5], zero[7:6]
  logic                  m_tuser;         // key_group[0]
  logic                  m_tlast;

  key_edge_predictor keys;
  int                cur_thr     = int'(THR_RESET);
  int                burst_left  = 0;
  bit                gaps_on     = 1'b1;
  int                ready_run   = 0;
  int                stall_run   = 0;
  int                idle_cycles = 0;

  joystick_event_to_key_edges_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stall the key output in runs, with an occasional long ready stretch
  always @(posedge clk) begin
    if (ready_run > 0) begin
      m_tready  <= 1'b1;
      ready_run <= ready_run - 1;
    end else if (stall_run > 0) begin
      m_tready  <= 1'b0;
      stall_run <= stall_run - 1;
    end else begin
      m_tready  <= 1'b1;
      ready_run <= ($urandom_range(0, 9) == 0) ? 150 : int'($urandom_range(0, 12));
      stall_run <= int'($urandom_range(1, 10));
    end
  end

  // Feed accepted requests to the model and check every delivered key event
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) keys.accept_request(s_tuser, s_tdata[7:0], s_tdata[23:8]);
      if (m_tvalid && m_tready) begin
        keys.check_key(key_event_t'({m_tuser, m_tdata[4:0], m_tdata[5], m_tlast}));
      end
    end
  end

  // Abort when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request and hold it until accepted; open a new burst after an optional gap
  task automatic send_request(input logic [1:0] cmd, input logic [7:0] num,
                              input logic [15:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = int'($urandom_range(1, 16));
      gap = gaps_on ? int'($urandom_range(0, 8)) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {value, num};
    do @(posedge clk); while (!s_tready);
  endtask

  // Mostly well-formed joystick traffic, with out-of-range numbers mixed in
  task automatic send_random(input int count);
    logic [1:0]  cmd;
    logic [7:0]  num;
    logic [15:0] value;
    int          pick;
    repeat (count) begin
      pick  = int'($urandom_range(0, 99));
      num   = 8'($urandom);
      value = 16'($urandom);
      if (pick < 36) begin
        cmd = CMD_BUTTON;
        if ($urandom_range(0, 9) != 0) num = 8'($urandom_range(0, NUM_BUTTONS_DEF - 1));
        else num = 8'($urandom_range(NUM_BUTTONS_DEF, 255));
        if ($urandom_range(0, 1) == 0) value = '0;
      end else if (pick < 72) begin
        cmd = CMD_AXIS;
        if ($urandom_range(0, 9) != 0) num = 8'($urandom_range(0, NUM_AXES_DEF - 1));
        else num = 8'($urandom_range(NUM_AXES_DEF, 255));
        // Favor samples on and just past the threshold
        case ($urandom_range(0, 7))
          0: value = 16'h8000;
          1: value = 16'h7FFF;
          2: value = 16'(cur_thr);
          3: value = 16'(-cur_thr);
          4: value = 16'(cur_thr + 1);
          5: value = 16'(-cur_thr - 1);
          6: value = '0;
          default: ;
        endcase
      end else if (pick < 95) begin
        cmd = CMD_TICK;
      end else begin
        cmd = CMD_RELEASE;
      end
      send_request(cmd, num, value);
    end
  endtask

  // Drop valid, let the model see the last request, wait out all owed key events,
  // then let the back finish
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (keys.expected_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write both registers on consecutive cycles
  task automatic configure(input logic [CFG_DATA_W-1:0] thr, input logic en);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_AXIS_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    keys.write_register(REG_AXIS_THRESHOLD, thr);
    cfg_index <= REG_DEVICE_ENABLE;
    cfg_data  <= CFG_DATA_W'(en);
    @(posedge clk);
    keys.write_register(REG_DEVICE_ENABLE, CFG_DATA_W'(en));
    cfg_wen <= 1'b0;
    cur_thr = int'(thr);
  endtask

  initial begin
    keys = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: button edges and repeats, out-of-range numbers, threshold edges
    send_request(CMD_BUTTON, 8'd0, 16'h0001);
    send_request(CMD_BUTTON, 8'd31, 16'h8000);
    send_request(CMD_BUTTON, 8'd31, 16'h7FFF);
    send_request(CMD_BUTTON, 8'd0, 16'h0000);
    send_request(CMD_BUTTON, 8'd32, 16'h0001);
    send_request(CMD_BUTTON, 8'd255, 16'hFFFF);
    send_request(CMD_AXIS, 8'd0, 16'h8000);
    send_request(CMD_AXIS, 8'd7, 16'h7FFF);
    send_request(CMD_AXIS, 8'd8, 16'h7FFF);
    send_request(CMD_AXIS, 8'd255, 16'h8000);
    send_request(CMD_AXIS, 8'd3, 16'(cur_thr));
    send_request(CMD_AXIS, 8'd4, 16'(-cur_thr));
    send_request(CMD_AXIS, 8'd5, 16'(cur_thr + 1));
    send_request(CMD_AXIS, 8'd6, 16'(-cur_thr - 1));
    send_request(CMD_TICK, 8'hFF, 16'hFFFF);
    send_request(CMD_TICK, 8'h00, 16'h0000);
    send_request(CMD_AXIS, 8'd0, 16'h0000);
    send_request(CMD_TICK, 8'h00, 16'h0000);
    send_request(CMD_BUTTON, 8'd5, 16'h0001);
    send_request(CMD_RELEASE, 8'hA5, 16'h5A5A);
    send_request(CMD_RELEASE, 8'h00, 16'h0000);
    send_request(CMD_TICK, 8'h00, 16'h0000);
    settle();

    // Random phases across threshold extremes, a disabled stretch and a gap-free run
    configure('0, 1'b1);
    send_random(50);
    settle();
    configure('1, 1'b1);
    send_random(40);
    settle();
    configure(CFG_DATA_W'($urandom), 1'b0);
    send_random(15);
    settle();
    configure(CFG_DATA_W'($urandom_range(1, 32766)), 1'b1);
    send_random(50);
    settle();
    gaps_on = 1'b0;
    configure(THR_RESET, 1'b1);
    send_random(50);
    settle();

    if (keys.mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

// ===== joystick_event_to_key_edges_unit.f =====
+incdir+rtl
rtl/jeke_pkg.sv
rtl/jeke_front.sv
rtl/jeke_queue.sv
rtl/jeke_back.sv
rtl/joystick_event_to_key_edges_unit.sv
tb/tb_top.sv
